// ----- rtl/assert_macros.svh -----
// assertion macros for the top level rtl file of the joystick block
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JPD_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JPD_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define JPD_ASSERT(name, clk, rst_n, prop, msg)
`define JPD_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/jpd_pkg.sv -----
// types and constants of the joystick percent and direction block
// no dependencies
package jpd_pkg;

	localparam int DIV_STEPS = 15;
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam int MOVE_STEP = 5;
	localparam int SENS_STEP = 9;
	localparam int PCT_MAX = 100;

	typedef enum logic [1:0] {
		REG_X_OFFSET    = 2'd0,
		REG_Y_OFFSET    = 2'd1,
		REG_SENSITIVITY = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		DIR_NEUTRAL = 3'd0,
		DIR_RIGHT   = 3'd1,
		DIR_LEFT    = 3'd2,
		DIR_UP      = 3'd3,
		DIR_DOWN    = 3'd4
	} dir_t;

	typedef struct packed {
		logic              done;
		logic signed [7:0] pct;
	} lane_res_t;

endpackage

// ----- rtl/jpd_lane.sv -----
// one axis lane: offset removal, scaling by 100 and iterative restoring divide
// depends on jpd_pkg
module jpd_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [7:0]         sample,
	input  logic signed [7:0]  offset,
	output jpd_pkg::lane_res_t res
);
	import jpd_pkg::*;

	logic signed [9:0] n;
	logic              neg;
	logic signed [8:0] d;
	logic              dz;
	logic [8:0]        mag_n;
	logic [14:0]       num;

	logic              busy_q;
	logic              fin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [14:0]       quo_q;
	logic [7:0]        rem_q;
	logic [7:0]        d_q;
	logic              neg_q;
	logic              dz_q;
	logic              nz_q;

	logic [8:0]        trial;
	logic [7:0]        diff;
	logic              ge;
	logic [6:0]        mag7;
	logic [7:0]        mag8;

	always_comb begin
		n = $signed({2'b00, sample}) - $signed({{2{offset[7]}}, offset}) - 10'sd127;
		neg = n[9];
		d = neg ? (9'sd127 + $signed({offset[7], offset}))
			: (9'sd127 - $signed({offset[7], offset}));
		dz = d[8] | (d == 9'sd0);
		mag_n = neg ? 9'(-n) : n[8:0];
		num = 15'(mag_n) * 15'(PCT_MAX);
	end

	always_comb begin
		trial = {rem_q, quo_q[14]};
		diff = trial[7:0] - d_q;
		ge = (trial >= {1'b0, d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			d_q <= d[7:0];
			neg_q <= neg;
			dz_q <= dz;
			nz_q <= (mag_n != 9'd0);
		end else if (busy_q) begin
			quo_q <= {quo_q[13:0], ge};
			rem_q <= ge ? diff : trial[7:0];
		end
	end

	always_comb begin
		if (dz_q) begin
			mag7 = nz_q ? 7'(PCT_MAX) : 7'd0;
		end else if ((|quo_q[14:7]) || (quo_q[6:0] > 7'(PCT_MAX))) begin
			mag7 = 7'(PCT_MAX);
		end else begin
			mag7 = quo_q[6:0];
		end
		mag8 = {1'b0, mag7};
		res.done = fin_q;
		res.pct = neg_q ? $signed(-mag8) : $signed(mag8);
	end

endmodule

// ----- rtl/jpd_merge.sv -----
// merge stage: movement test against held position, direction classifier,
// held state and result payload registers; depends on jpd_pkg
module jpd_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               commit,
	input  logic               button,
	input  logic [3:0]         sens,
	input  jpd_pkg::lane_res_t x_res,
	input  jpd_pkg::lane_res_t y_res,
	output logic               updated,
	output logic signed [7:0]  x_pct,
	output logic signed [7:0]  y_pct,
	output logic [2:0]         dir
);
	import jpd_pkg::*;

	logic signed [7:0] held_x_q;
	logic signed [7:0] held_y_q;
	dir_t              held_dir_q;
	logic              updated_q;

	logic signed [8:0] dx;
	logic signed [8:0] dy;
	logic [8:0]        adx;
	logic [8:0]        ady;
	logic              moved;
	logic              upd;
	logic [7:0]        th;
	logic signed [8:0] ths;
	logic signed [8:0] xs;
	logic signed [8:0] ys;
	logic [7:0]        ax;
	logic [7:0]        ay;
	logic              xdom;
	dir_t              dir_new;

	always_comb begin
		dx = $signed({x_res.pct[7], x_res.pct}) - $signed({held_x_q[7], held_x_q});
		dy = $signed({y_res.pct[7], y_res.pct}) - $signed({held_y_q[7], held_y_q});
		adx = dx[8] ? 9'(-dx) : 9'(dx);
		ady = dy[8] ? 9'(-dy) : 9'(dy);
		moved = (adx > 9'(MOVE_STEP)) || (ady > 9'(MOVE_STEP));
		upd = moved | button;
	end

	always_comb begin
		th = {4'b0000, sens} * 8'(SENS_STEP);
		ths = $signed({1'b0, th});
		xs = $signed({x_res.pct[7], x_res.pct});
		ys = $signed({y_res.pct[7], y_res.pct});
		ax = x_res.pct[7] ? 8'(-x_res.pct) : 8'(x_res.pct);
		ay = y_res.pct[7] ? 8'(-y_res.pct) : 8'(y_res.pct);
		xdom = (ax >= ay);
		if (xdom && (xs > ths)) begin
			dir_new = DIR_RIGHT;
		end else if (xdom && (xs < -ths)) begin
			dir_new = DIR_LEFT;
		end else if (!xdom && (ys > ths)) begin
			dir_new = DIR_UP;
		end else if (!xdom && (ys < -ths)) begin
			dir_new = DIR_DOWN;
		end else begin
			dir_new = DIR_NEUTRAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q <= '0;
			held_y_q <= '0;
			held_dir_q <= DIR_NEUTRAL;
			updated_q <= 1'b0;
		end else if (commit) begin
			updated_q <= upd;
			if (upd) begin
				held_x_q <= x_res.pct;
				held_y_q <= y_res.pct;
				held_dir_q <= dir_new;
			end
		end
	end

	assign updated = updated_q;
	assign x_pct = held_x_q;
	assign y_pct = held_y_q;
	assign dir = held_dir_q;

endmodule

// ----- rtl/joystick_percent_and_direction.sv -----
// top level of the joystick percent and direction block: apb registers,
// item control, two axis lanes and the merge stage
// depends on jpd_pkg, jpd_lane, jpd_merge and assert_macros.svh
//
// channel   signals                                   width  role
// config    psel penable pwrite paddr pwdata prdata   32     offsets, sensitivity
// input     in_valid in_ready x_sample y_sample button 8/8/1 raw samples
// output    out_valid out_ready updated x_percent      1/8/8/3 held position
//           y_percent direction
//
// an item is loaded into both axis lanes on acceptance, runs 15 restoring
// divide steps in them side by side and is committed once the lanes signal
// done; the result then enters the output register.
// reset is asynchronous: clears held position, direction and offsets, sets sensitivity to 1.
// a stalled output holds the finished item in the lanes until the output
// register frees up; a new item is taken while a result waits in the output register, not in the lanes.
module joystick_percent_and_direction (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        x_sample,
	input  logic [7:0]        y_sample,
	input  logic              button,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              updated,
	output logic signed [7:0] x_percent,
	output logic signed [7:0] y_percent,
	output logic [2:0]        direction
);
	import jpd_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t            state_q;
	logic              out_valid_q;
	logic              button_q;
	logic signed [7:0] x_off_q;
	logic signed [7:0] y_off_q;
	logic [3:0]        sens_q;

	logic              wr_en;
	reg_idx_t          reg_idx;
	logic              start;
	logic              commit;
	lane_res_t         x_res;
	lane_res_t         y_res;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= '0;
			y_off_q <= '0;
			sens_q <= 4'd1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_X_OFFSET: x_off_q <= pwdata[7:0];
				REG_Y_OFFSET: y_off_q <= pwdata[7:0];
				REG_SENSITIVITY: sens_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_X_OFFSET: prdata = {24'd0, x_off_q};
			REG_Y_OFFSET: prdata = {24'd0, y_off_q};
			REG_SENSITIVITY: prdata = {28'd0, sens_q};
			default: prdata = '0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign start = in_valid & in_ready;
	assign commit = (((state_q == ST_RUN) && x_res.done) || (state_q == ST_HOLD))
		&& (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			button_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						button_q <= button;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (x_res.done) begin
						state_q <= commit ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	jpd_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sample (x_sample),
		.offset (x_off_q),
		.res    (x_res)
	);

	jpd_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sample (y_sample),
		.offset (y_off_q),
		.res    (y_res)
	);

	jpd_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.button  (button_q),
		.sens    (sens_q),
		.x_res   (x_res),
		.y_res   (y_res),
		.updated (updated),
		.x_pct   (x_percent),
		.y_pct   (y_percent),
		.dir     (direction)
	);

	assign out_valid = out_valid_q;

	`JPD_ASSERT(a_lanes_in_step, clk, arst_n, x_res.done == y_res.done, "lanes out of step")
	`JPD_ASSERT(a_x_range, clk, arst_n, x_percent <= 8'sd100 && x_percent >= -8'sd100, "x range")
	`JPD_ASSERT(a_y_range, clk, arst_n, y_percent <= 8'sd100 && y_percent >= -8'sd100, "y range")
	`JPD_ASSERT(a_dir_code, clk, arst_n, direction <= DIR_DOWN, "bad direction code")
	`JPD_ASSERT(a_held_change, clk, arst_n, $changed(x_percent) |-> updated, "stray x change")
	`JPD_NEVER(a_done_idle, clk, arst_n, x_res.done && state_q != ST_RUN, "done outside run")

endmodule

// ----- test/testbench.sv -----
// self-checking testbench of the joystick percent and direction block
// drives samples and apb register writes, predicts every status item and
// checks it; depends on jpd_pkg and the joystick_percent_and_direction rtl
`timescale 1ns / 100ps

module testbench;
	import jpd_pkg::*;

	typedef struct packed {
		logic              updated;
		logic signed [7:0] x_pct;
		logic signed [7:0] y_pct;
		logic [2:0]        dir;
	} joy_status_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        x_sample = '0;
	logic [7:0]        y_sample = '0;
	logic              button = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              updated;
	logic signed [7:0] x_percent;
	logic signed [7:0] y_percent;
	logic [2:0]        direction;

	joy_status_t       pending_status[$];
	int                mismatches = 0;
	bit                calm = 1'b0;

	logic signed [7:0] x_ofs = 8'sd0;
	logic signed [7:0] y_ofs = 8'sd0;
	logic [3:0]        sens = 4'd1;
	int                held_x = 0;
	int                held_y = 0;
	dir_t              held_dir = DIR_NEUTRAL;
	logic [7:0]        last_x = 8'd127;
	logic [7:0]        last_y = 8'd127;

	joystick_percent_and_direction uut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int axis_percent_of(logic [7:0] sample, logic signed [7:0] ofs);
		int s;
		int o;
		int n;
		int d;
		int p;
		s = int'(sample);
		o = int'(ofs);
		n = s - o - 127;
		d = (n >= 0) ? 127 - o : 127 + o;
		if (d <= 0) begin
			if (n > 0) return PCT_MAX;
			if (n < 0) return -PCT_MAX;
			return 0;
		end
		p = (n * 100) / d;
		if (p > PCT_MAX) p = PCT_MAX;
		if (p < -PCT_MAX) p = -PCT_MAX;
		return p;
	endfunction

	function automatic dir_t direction_of(int x, int y, logic [3:0] s);
		int th;
		int ax;
		int ay;
		th = int'(s) * SENS_STEP;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		if (ax >= ay) begin
			if (x > th) return DIR_RIGHT;
			if (x < -th) return DIR_LEFT;
		end else begin
			if (y > th) return DIR_UP;
			if (y < -th) return DIR_DOWN;
		end
		return DIR_NEUTRAL;
	endfunction

	function automatic void predict_status(logic [7:0] xs, logic [7:0] ys, logic b);
		int nx;
		int ny;
		int dx;
		int dy;
		bit refresh;
		joy_status_t st;
		nx = axis_percent_of(xs, x_ofs);
		ny = axis_percent_of(ys, y_ofs);
		dx = nx - held_x;
		dy = ny - held_y;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		refresh = (dx > MOVE_STEP) || (dy > MOVE_STEP) || b;
		if (refresh) begin
			held_x = nx;
			held_y = ny;
			held_dir = direction_of(nx, ny, sens);
		end
		st.updated = refresh;
		st.x_pct = held_x[7:0];
		st.y_pct = held_y[7:0];
		st.dir = held_dir;
		pending_status.push_back(st);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_sample(logic [7:0] xs, logic [7:0] ys, logic b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_sample <= xs;
		y_sample <= ys;
		button <= b;
		do @(posedge clk); while (!in_ready);
		predict_status(xs, ys, b);
		last_x = xs;
		last_y = ys;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_X_OFFSET:    x_ofs = value[7:0];
			REG_Y_OFFSET:    y_ofs = value[7:0];
			REG_SENSITIVITY: sens = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int xo, int yo, int s, bit noisy);
		logic [31:0] noise;
		wait_drained();
		noise = noisy ? $urandom : 32'd0;
		apb_write(REG_X_OFFSET, {noise[31:8], 8'(xo)});
		apb_write(REG_Y_OFFSET, {noise[31:8], 8'(yo)});
		apb_write(REG_SENSITIVITY, {noise[31:4], 4'(s)});
	endtask

	task automatic send_mixed(int count);
		int r;
		int tx;
		int ty;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else if (r < 85) begin
				// small jitter around the last sample, mostly below the move step
				tx = int'(last_x) + $urandom_range(0, 8) - 4;
				ty = int'(last_y) + $urandom_range(0, 8) - 4;
				if (tx < 0) tx = 0;
				if (tx > 255) tx = 255;
				if (ty < 0) ty = 0;
				if (ty > 255) ty = 255;
				send_sample(tx[7:0], ty[7:0], ($urandom_range(0, 9) == 0));
			end else begin
				send_sample(last_x, last_y, 1'b1);
			end
		end
	endtask

	task automatic test_reset_state();
		send_sample(8'd127, 8'd127, 1'b0);
		send_sample(8'd127, 8'd127, 1'b1);
	endtask

	task automatic test_field_extremes();
		send_sample(8'd0, 8'd0, 1'b0);
		send_sample(8'd255, 8'd255, 1'b0);
		send_sample(8'd255, 8'd0, 1'b0);
		send_sample(8'd0, 8'd255, 1'b1);
		send_sample(8'd127, 8'd255, 1'b0);
		send_sample(8'd127, 8'd0, 1'b0);
		// right at the dead zone edge, then just past it, then a small move
		send_sample(8'd139, 8'd127, 1'b1);
		send_sample(8'd140, 8'd127, 1'b1);
		send_sample(8'd141, 8'd127, 1'b0);
	endtask

	task automatic test_special_cases();
		// equal magnitudes with no dead zone
		set_config(0, 0, 0, 1'b0);
		send_sample(8'd255, 8'd255, 1'b1);
		send_sample(8'd0, 8'd0, 1'b1);
		send_sample(8'd0, 8'd255, 1'b1);
		// zero divisor on x, clamping on y, dead zone wider than full scale
		set_config(127, 126, 12, 1'b0);
		send_sample(8'd255, 8'd255, 1'b1);
		send_sample(8'd254, 8'd0, 1'b1);
		send_sample(8'd0, 8'd127, 1'b1);
		// most negative offset
		set_config(-128, -126, 15, 1'b0);
		send_sample(8'd255, 8'd0, 1'b1);
		send_sample(8'd0, 8'd1, 1'b1);
		send_sample(8'd128, 8'd200, 1'b0);
	endtask

	task automatic test_register_sweep();
		int xo;
		int yo;
		int s;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin xo = -126; yo = -126; s = 0; end
				1: begin xo = 126; yo = 126; s = 11; end
				2: begin xo = 0; yo = 0; s = 1; end
				3: begin xo = -126; yo = 126; s = 5; end
				4: begin xo = 126; yo = -126; s = 11; end
				default: begin
					xo = $urandom_range(0, 252) - 126;
					yo = $urandom_range(0, 252) - 126;
					s = $urandom_range(0, 15);
				end
			endcase
			set_config(xo, yo, s, phase >= 5);
			send_mixed(100);
		end
	endtask

	task automatic test_drain_pause();
		set_config(20, -40, 3, 1'b1);
		calm = 1'b1;
		send_mixed(60);
		calm = 1'b0;
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		send_mixed(60);
	endtask

	initial begin
		int stall;
		joy_status_t want;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_status.size() == 0) begin
				report_mismatch("item with none pending, x_percent", int'(x_percent), 0);
			end else begin
				want = pending_status.pop_front();
				if (updated !== want.updated)
					report_mismatch("updated", int'(updated), int'(want.updated));
				if (x_percent !== want.x_pct)
					report_mismatch("x_percent", int'(x_percent), int'(want.x_pct));
				if (y_percent !== want.y_pct)
					report_mismatch("y_percent", int'(y_percent), int'(want.y_pct));
				if (direction !== want.dir)
					report_mismatch("direction", int'(direction), int'(want.dir));
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_field_extremes();
		test_special_cases();
		test_register_sweep();
		test_drain_pause();
		wait_drained();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
